### sv/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg: shared types and constants for the month calendar grid
// Request codes, the classified command word, queue status, the back-end
// state encoding, and small calendar lookup functions.
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int CELL_W  = 6;
  localparam int REQ_W   = 2;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);

  // Reciprocal constants: (y * 5243) >> 19 is y / 100 for y below 43699, and
  // (s * 9362) >> 16 is s / 7 or one less for the sums that occur here.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  localparam logic [13:0] DIV7_MUL     = 14'd9362;
  localparam int          DIV7_SHIFT   = 16;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_PREV   = 2'd0,
    REQ_NEXT   = 2'd1,
    REQ_TODAY  = 2'd2,
    REQ_REDRAW = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t           kind;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADJ,
    ST_SUM,
    ST_MOD,
    ST_REM,
    ST_EMIT
  } back_state_t;

  // Days in a month, February taking the leap flag into account.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    begin
      case (month)
        4'd2:                      len = leap ? DAY_W'(29) : DAY_W'(28);
        4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
        default:                   len = DAY_W'(31);
      endcase
      return len;
    end
  endfunction

  // floor(3 * (m + 1) / 5) for the shifted month range 3..14.
  function automatic logic [3:0] month_term(input logic [MONTH_W-1:0] m);
    logic [3:0] t;
    begin
      case (m)
        4'd3:         t = 4'd2;
        4'd4, 4'd5:   t = 4'd3;
        4'd6, 4'd7:   t = 4'd4;
        4'd8:         t = 4'd5;
        4'd9, 4'd10:  t = 4'd6;
        4'd11, 4'd12: t = 4'd7;
        4'd13:        t = 4'd8;
        4'd14:        t = 4'd9;
        default:      t = 4'd0;
      endcase
      return t;
    end
  endfunction

endpackage

### sv/mcg_req_if.sv
// ----------------------------------------------------------------------------
// mcg_req_if: request channel
// Valid/ready channel carrying one calendar request word.
// ----------------------------------------------------------------------------
interface mcg_req_if;
  import mcg_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [YEAR_W-1:0]  today_year;
  logic [MONTH_W-1:0] today_month;
  logic [DAY_W-1:0]   today_day;

  modport source (output valid, output req_type, output today_year,
                  output today_month, output today_day, input ready);
  modport sink   (input valid, input req_type, input today_year,
                  input today_month, input today_day, output ready);
endinterface

### sv/mcg_day_if.sv
// ----------------------------------------------------------------------------
// mcg_day_if: day result channel
// Valid/ready channel carrying one laid-out day word.
// ----------------------------------------------------------------------------
interface mcg_day_if;
  import mcg_pkg::*;

  logic               valid;
  logic               ready;
  logic [CELL_W-1:0]  cell_index;
  logic [DAY_W-1:0]   day_number;
  logic               is_today;
  logic [YEAR_W-1:0]  view_year;
  logic [MONTH_W-1:0] view_month;
  logic               last;

  modport source (output valid, output cell_index, output day_number,
                  output is_today, output view_year, output view_month,
                  output last, input ready);
  modport sink   (input valid, input cell_index, input day_number,
                  input is_today, input view_year, input view_month,
                  input last, output ready);
endinterface

### sv/mcg_front.sv
// ----------------------------------------------------------------------------
// mcg_front: request intake
// Accepts request words, decodes the request kind and clamps the supplied
// today date into range, then hands a command word to the queue.
// ----------------------------------------------------------------------------
module mcg_front (
  mcg_req_if.sink               in_req,
  input  mcg_pkg::q_status_t    q_status,
  output logic                  push,
  output mcg_pkg::cmd_t         push_cmd
);
  import mcg_pkg::*;

  logic [YEAR_W-1:0]  year_c;
  logic [MONTH_W-1:0] month_c;
  logic [DAY_W-1:0]   day_c;

  assign in_req.ready = !q_status.full;
  assign push         = in_req.valid && !q_status.full;

  always_comb begin
    year_c = in_req.today_year;
    if (year_c == '0) begin
      year_c = YEAR_MIN;
    end else if (year_c > YEAR_MAX) begin
      year_c = YEAR_MAX;
    end

    month_c = in_req.today_month;
    if (month_c == '0) begin
      month_c = MONTH_JAN;
    end else if (month_c > MONTH_DEC) begin
      month_c = MONTH_DEC;
    end

    day_c = in_req.today_day;
    if (day_c == '0) begin
      day_c = DAY_FIRST;
    end
  end

  always_comb begin
    push_cmd.kind  = req_kind_t'(in_req.req_type);
    push_cmd.year  = year_c;
    push_cmd.month = month_c;
    push_cmd.day   = day_c;
  end

endmodule

### sv/mcg_queue.sv
// ----------------------------------------------------------------------------
// mcg_queue: command queue
// Short FIFO of command words between the intake and the layout engine.
// ----------------------------------------------------------------------------
module mcg_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mcg_pkg::cmd_t         push_cmd,
  input  logic                  pop,
  output mcg_pkg::cmd_t         pop_cmd,
  output mcg_pkg::q_status_t    q_status
);
  import mcg_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_cmd        = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### sv/mcg_back.sv
// ----------------------------------------------------------------------------
// mcg_back: month layout engine
// Applies each command to the shown month and the stored today date,
// computes the weekday of the 1st in setup states ST_ADJ to ST_REM, then emits
// one day word per cycle, while the output register is free or being taken.
// ----------------------------------------------------------------------------
module mcg_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mcg_pkg::q_status_t    q_status,
  input  mcg_pkg::cmd_t         pop_cmd,
  output logic                  pop,
  mcg_day_if.source             out_day
);
  import mcg_pkg::*;

  back_state_t        state_r, state_nxt;

  logic [YEAR_W-1:0]  view_year_r, view_year_nxt;
  logic [MONTH_W-1:0] view_month_r, view_month_nxt;
  logic [YEAR_W-1:0]  saved_year_r, saved_year_nxt;
  logic [MONTH_W-1:0] saved_month_r, saved_month_nxt;
  logic [DAY_W-1:0]   saved_day_r, saved_day_nxt;

  logic [YEAR_W-1:0]  adj_year_r, adj_year_nxt;
  logic [MONTH_W-1:0] adj_month_r, adj_month_nxt;
  logic [26:0]        prod_adj_r, prod_adj_nxt;
  logic [26:0]        prod_view_r, prod_view_nxt;
  logic [14:0]        sum_r, sum_nxt;
  logic [DAY_W-1:0]   ndays_r, ndays_nxt;
  logic               same_r, same_nxt;
  logic [10:0]        q7_r, q7_nxt;
  logic [2:0]         off_r, off_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic [DAY_W-1:0]   day_num_r, day_num_nxt;
  logic               today_r, today_nxt;
  logic [YEAR_W-1:0]  oyear_r, oyear_nxt;
  logic [MONTH_W-1:0] omonth_r, omonth_nxt;
  logic               last_r, last_nxt;

  logic               slot_free;
  logic               load;
  logic               final_day;
  logic [6:0]         q100_adj, q100_view;
  logic [YEAR_W-1:0]  rem100;
  logic               leap;
  logic [28:0]        prod7;
  logic [14:0]        rem7_wide;
  logic [3:0]         rem7;

  assign slot_free = !out_valid_r || out_day.ready;
  assign load      = (state_r == ST_EMIT) && slot_free;
  assign final_day = (day_r == ndays_r);
  assign pop       = (state_r == ST_IDLE) && !q_status.empty;

  assign q100_adj  = prod_adj_r[DIV100_SHIFT+6:DIV100_SHIFT];
  assign q100_view = prod_view_r[DIV100_SHIFT+6:DIV100_SHIFT];
  assign rem100    = view_year_r - YEAR_W'(YEAR_W'(q100_view) * YEAR_W'(100));
  assign leap      = ((view_year_r[1:0] == 2'b00) && (rem100 != '0)) ||
                     ((rem100 == '0) && (q100_view[1:0] == 2'b00));
  assign prod7     = 29'(sum_r) * 29'(DIV7_MUL);
  assign rem7_wide = sum_r - 15'(15'(q7_r) * 15'd7);
  assign rem7      = rem7_wide[3:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_status.empty) state_nxt = ST_ADJ;
      ST_ADJ:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_REM;
      ST_REM:  state_nxt = ST_EMIT;
      ST_EMIT: if (load && final_day) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    view_year_nxt   = view_year_r;
    view_month_nxt  = view_month_r;
    saved_year_nxt  = saved_year_r;
    saved_month_nxt = saved_month_r;
    saved_day_nxt   = saved_day_r;
    adj_year_nxt    = adj_year_r;
    adj_month_nxt   = adj_month_r;
    prod_adj_nxt    = prod_adj_r;
    prod_view_nxt   = prod_view_r;
    sum_nxt         = sum_r;
    ndays_nxt       = ndays_r;
    same_nxt        = same_r;
    q7_nxt          = q7_r;
    off_nxt         = off_r;
    day_nxt         = day_r;
    out_valid_nxt   = out_valid_r;
    cell_nxt        = cell_r;
    day_num_nxt     = day_num_r;
    today_nxt       = today_r;
    oyear_nxt       = oyear_r;
    omonth_nxt      = omonth_r;
    last_nxt        = last_r;

    if (out_valid_r && out_day.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          unique case (pop_cmd.kind)
            REQ_PREV: begin
              if (view_month_r <= MONTH_JAN) begin
                view_month_nxt = MONTH_DEC;
                if (view_year_r > YEAR_MIN) view_year_nxt = view_year_r - 1'b1;
              end else begin
                view_month_nxt = view_month_r - 1'b1;
              end
            end
            REQ_NEXT: begin
              if (view_month_r >= MONTH_DEC) begin
                if (view_year_r < YEAR_MAX) begin
                  view_month_nxt = MONTH_JAN;
                  view_year_nxt  = view_year_r + 1'b1;
                end
              end else begin
                view_month_nxt = view_month_r + 1'b1;
              end
            end
            REQ_TODAY: begin
              saved_year_nxt  = pop_cmd.year;
              saved_month_nxt = pop_cmd.month;
              saved_day_nxt   = pop_cmd.day;
              view_year_nxt   = pop_cmd.year;
              view_month_nxt  = pop_cmd.month;
            end
            REQ_REDRAW: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADJ: begin
        // January and February count as months 13 and 14 of the year before.
        if (view_month_r <= MONTH_FEB) begin
          adj_year_nxt  = view_year_r - 1'b1;
          adj_month_nxt = view_month_r + MONTH_W'(12);
        end else begin
          adj_year_nxt  = view_year_r;
          adj_month_nxt = view_month_r;
        end
        prod_adj_nxt  = 27'(adj_year_nxt) * 27'(DIV100_MUL);
        prod_view_nxt = 27'(view_year_r) * 27'(DIV100_MUL);
      end
      ST_SUM: begin
        sum_nxt = 15'd2 + 15'({adj_month_r, 1'b0}) + 15'(month_term(adj_month_r))
                + 15'(adj_year_r) + 15'(adj_year_r >> 2) - 15'(q100_adj)
                + 15'(q100_adj >> 2);
        ndays_nxt = month_len(view_month_r, leap);
        same_nxt  = (view_month_r == saved_month_r) && (view_year_r == saved_year_r);
      end
      ST_MOD: begin
        q7_nxt = prod7[DIV7_SHIFT+10:DIV7_SHIFT];
      end
      ST_REM: begin
        // The quotient estimate is exact or one short, so one subtract fixes it.
        off_nxt = (rem7 >= 4'd7) ? 3'(rem7 - 4'd7) : rem7[2:0];
        day_nxt = DAY_FIRST;
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          cell_nxt      = CELL_W'(off_r) + CELL_W'(day_r) - CELL_W'(1);
          day_num_nxt   = day_r;
          today_nxt     = same_r && (day_r == saved_day_r);
          oyear_nxt     = view_year_r;
          omonth_nxt    = view_month_r;
          last_nxt      = final_day;
          day_nxt       = day_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      view_year_r   <= YEAR_MIN;
      view_month_r  <= MONTH_JAN;
      saved_year_r  <= YEAR_MIN;
      saved_month_r <= MONTH_JAN;
      saved_day_r   <= DAY_FIRST;
      out_valid_r   <= 1'b0;
      day_r         <= DAY_FIRST;
    end else begin
      state_r       <= state_nxt;
      view_year_r   <= view_year_nxt;
      view_month_r  <= view_month_nxt;
      saved_year_r  <= saved_year_nxt;
      saved_month_r <= saved_month_nxt;
      saved_day_r   <= saved_day_nxt;
      out_valid_r   <= out_valid_nxt;
      day_r         <= day_nxt;
    end
  end

  always_ff @(posedge clk) begin
    adj_year_r  <= adj_year_nxt;
    adj_month_r <= adj_month_nxt;
    prod_adj_r  <= prod_adj_nxt;
    prod_view_r <= prod_view_nxt;
    sum_r       <= sum_nxt;
    ndays_r     <= ndays_nxt;
    same_r      <= same_nxt;
    q7_r        <= q7_nxt;
    off_r       <= off_nxt;
    cell_r      <= cell_nxt;
    day_num_r   <= day_num_nxt;
    today_r     <= today_nxt;
    oyear_r     <= oyear_nxt;
    omonth_r    <= omonth_nxt;
    last_r      <= last_nxt;
  end

  assign out_day.valid      = out_valid_r;
  assign out_day.cell_index = cell_r;
  assign out_day.day_number = day_num_r;
  assign out_day.is_today   = today_r;
  assign out_day.view_year  = oyear_r;
  assign out_day.view_month = omonth_r;
  assign out_day.last       = last_r;

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (view_month_r >= MONTH_JAN) && (view_month_r <= MONTH_DEC))
    else $error("shown month left the range 1 to 12");

  a_day_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> ((day_r >= DAY_FIRST) && (day_r <= ndays_r)))
    else $error("day counter ran past the end of the month");

  a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (off_r < 3'd7))
    else $error("weekday of the 1st out of range");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (load && final_day) |=> (out_valid_r && last_r && (state_r == ST_IDLE)))
    else $error("final day word not flagged or run not closed");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !pop)
    else $error("command taken while a month is still being laid out");

endmodule

### sv/month_calendar_grid_top.sv
// ----------------------------------------------------------------------------
// month_calendar_grid_top: month calendar grid
// Keeps a shown month and a stored today date and lays out one word per day.
// ----------------------------------------------------------------------------
// The layout engine takes each command through its weekday setup states and then
// emits the days of the month in turn; it takes no new command from the queue
// until the final day word of the month has been loaded.
// A two-entry command queue lets requests be taken while a month is emitted.
// Reset: synchronous, active low; shown month and today become January 1 of
// year 1, the queue empties and no day word is valid.
module month_calendar_grid_top (
  input  logic       clk,
  input  logic       rst_n,
  mcg_req_if.sink    in_req,
  mcg_day_if.source  out_day
);
  import mcg_pkg::*;

  q_status_t q_status;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      pop_cmd;

  mcg_front u_front (
    .in_req   (in_req),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  mcg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_status (q_status)
  );

  mcg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .pop_cmd  (pop_cmd),
    .pop      (pop),
    .out_day  (out_day)
  );

endmodule
